### design/trsr_pkg.sv
// Package for the triangle span rasterizer: widths, codes, beat structs,
// controller state type and the command/status bundles.
// No dependencies.
package trsr_pkg;

    localparam int COORD_BITS   = 11;
    localparam int MAX_ROWS_DEF = 2048;
    localparam int ROW_W        = COORD_BITS + 1;       // row counts and pointers
    localparam int P_W          = COORD_BITS + 4;       // Bresenham decision term
    localparam int AREA_W       = 2 * COORD_BITS + 2;   // doubled-area magnitude
    localparam int NUM_W        = AREA_W + 8;           // area times 255
    localparam int ENT_W        = 2 * COORD_BITS + 1;   // span table entry

    // Function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // Edge selection
    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    // Colour channels
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Multiplier sequence: six products, then a drain step
    localparam logic [2:0] MUL_LAST = 3'd6;
    localparam logic [2:0] DIV_TOP  = 3'd7;

    typedef struct packed {
        logic                  func;
        logic [COORD_BITS-1:0] ax;
        logic [COORD_BITS-1:0] ay;
        logic [COORD_BITS-1:0] bx;
        logic [COORD_BITS-1:0] by;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
    } t_in;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic                  last;
    } t_out;

    typedef struct packed {
        logic                  touched;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] right;
    } t_row_ent;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_EDGE_SETUP,
        S_MARK_RD,
        S_MARK_WR,
        S_SEEK_RD,
        S_SEEK_CHK,
        S_MUL,
        S_DIV_INIT,
        S_DIV_STEP,
        S_ADV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       clr_wr;
        logic       edge_setup;
        logic [1:0] edge_sel;
        logic       mark_rd;
        logic       mark_wr;
        logic       walk_adv;
        logic       seek_zero;
        logic       seek_rd;
        logic       seek_hit;
        logic       seek_inc;
        logic       seek_fail;
        logic       seek_next;
        logic       pix_start;
        logic       mul_en;
        logic [2:0] mul_k;
        logic       div_init;
        logic       div_step;
        logic       div_last;
        logic [1:0] ch;
        logic [2:0] div_b;
        logic       col_inc;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic ptr_ok;
        logic edge_skip;
        logic mark_ok;
        logic walk_last;
        logic touched;
        logic busy;
        logic col_lt_right;
        logic out_free;
    } t_sts;

endpackage

### design/trsr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module trsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### design/trsr_ctrl.sv
// Sequencer for load (clear, edge walk, seek) and pixel (areas, divide,
// advance, emit) operations. Depends on trsr_pkg.
module trsr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_func,
    output logic          o_in_ready,
    input  trsr_pkg::t_sts i_sts,
    output trsr_pkg::t_cmd o_cmd
);
    import trsr_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_edge, n_edge;
    logic [2:0] r_k, n_k;
    logic [1:0] r_ch, n_ch;
    logic [2:0] r_b, n_b;
    logic       r_pix, n_pix;

    // State and sequence counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_edge  <= EDGE_AB;
            r_k     <= '0;
            r_ch    <= CH_RED;
            r_b     <= '0;
            r_pix   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_edge  <= n_edge;
            r_k     <= n_k;
            r_ch    <= n_ch;
            r_b     <= n_b;
            r_pix   <= n_pix;
        end
    end

    // Next state and commands
    always_comb begin
        logic edge_end;
        edge_end   = 1'b0;
        n_state    = r_state;
        n_edge     = r_edge;
        n_k        = r_k;
        n_ch       = r_ch;
        n_b        = r_b;
        n_pix      = r_pix;
        o_cmd      = '0;
        o_cmd.edge_sel = r_edge;
        o_cmd.mul_k    = r_k;
        o_cmd.ch       = r_ch;
        o_cmd.div_b    = r_b;
        o_in_ready = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_func == FUNC_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_CLEAR;
                    end else if (i_sts.busy) begin
                        o_cmd.pix_start = 1'b1;
                        n_pix   = 1'b1;
                        n_k     = '0;
                        n_state = S_MUL;
                    end
                end
            end
            S_CLEAR: begin
                if (i_sts.ptr_ok) begin
                    o_cmd.clr_wr = 1'b1;
                end else begin
                    n_edge  = EDGE_AB;
                    n_state = S_EDGE_SETUP;
                end
            end
            S_EDGE_SETUP: begin
                if (i_sts.edge_skip) begin
                    edge_end = 1'b1;
                end else begin
                    o_cmd.edge_setup = 1'b1;
                    n_state = S_MARK_RD;
                end
            end
            S_MARK_RD: begin
                if (i_sts.mark_ok) begin
                    o_cmd.mark_rd = 1'b1;
                    n_state = S_MARK_WR;
                end else begin
                    o_cmd.walk_adv = 1'b1;
                    edge_end = i_sts.walk_last;
                end
            end
            S_MARK_WR: begin
                o_cmd.mark_wr = 1'b1;
                if (i_sts.walk_last) begin
                    edge_end = 1'b1;
                end else begin
                    n_state = S_MARK_RD;
                end
            end
            S_SEEK_RD: begin
                if (i_sts.ptr_ok) begin
                    o_cmd.seek_rd = 1'b1;
                    n_state = S_SEEK_CHK;
                end else begin
                    o_cmd.seek_fail = 1'b1;
                    n_state = r_pix ? S_EMIT : S_IDLE;
                end
            end
            S_SEEK_CHK: begin
                if (i_sts.touched) begin
                    o_cmd.seek_hit = 1'b1;
                    n_state = r_pix ? S_EMIT : S_IDLE;
                end else begin
                    o_cmd.seek_inc = 1'b1;
                    n_state = S_SEEK_RD;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_k == MUL_LAST) begin
                    n_ch    = CH_RED;
                    n_state = S_DIV_INIT;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_b     = DIV_TOP;
                n_state = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                o_cmd.div_step = 1'b1;
                if (r_b == 3'd0) begin
                    o_cmd.div_last = 1'b1;
                    if (r_ch == CH_BLUE) begin
                        n_state = S_ADV;
                    end else begin
                        n_ch    = r_ch + 2'd1;
                        n_state = S_DIV_INIT;
                    end
                end else begin
                    n_b = r_b - 3'd1;
                end
            end
            S_ADV: begin
                if (i_sts.col_lt_right) begin
                    o_cmd.col_inc = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.seek_next = 1'b1;
                    n_state = S_SEEK_RD;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // End of one edge: next edge, or seek the first span
        if (edge_end) begin
            if (r_edge == EDGE_CA) begin
                o_cmd.seek_zero = 1'b1;
                n_pix   = 1'b0;
                n_state = S_SEEK_RD;
            end else begin
                n_edge  = r_edge + 2'd1;
                n_state = S_EDGE_SETUP;
            end
        end
    end

endmodule

### design/trsr_dp.sv
// Datapath: vertex and span registers, span table, Bresenham stepper,
// shared area multiplier, restoring divider, output register.
// Depends on trsr_pkg and trsr_ram.
module trsr_dp #(
    parameter int MAX_ROWS = trsr_pkg::MAX_ROWS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  trsr_pkg::t_in   i_in_data,
    input  trsr_pkg::t_cmd  i_cmd,
    output trsr_pkg::t_sts  o_sts,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output trsr_pkg::t_out  o_out_data
);
    import trsr_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int ADDR_W = $clog2(MAX_ROWS);

    // Triangle and cursor registers
    logic [C-1:0]      r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [C-1:0]      r_top;
    logic [ROW_W-1:0]  r_cnt;
    logic [ROW_W-1:0]  r_ptr;
    logic [ROW_W-1:0]  r_cur_row;
    logic [C-1:0]      r_cur_col, r_cur_right;
    logic              r_busy;
    // Edge walk
    logic              r_xmaj, r_dir;
    logic [C-1:0]      r_maj, r_pos, r_rem;
    logic [C:0]        r_2md, r_2len;
    logic signed [P_W-1:0] r_p;
    // Pixel arithmetic
    logic [C-1:0]      r_px, r_py;
    logic signed [AREA_W-1:0] r_prod, r_acc;
    logic [AREA_W-1:0] r_area [3];
    logic [NUM_W-1:0]  r_drem;
    logic              r_dzero, r_dsat;
    logic [7:0]        r_q;
    logic [7:0]        r_rgb [3];
    // Output
    logic              r_out_valid;
    t_out              r_out;

    // Bounds of a new triangle
    logic [C-1:0]      w_lo, w_hi;
    always_comb begin
        w_lo = i_in_data.ay;
        w_hi = i_in_data.ay;
        if (i_in_data.by < w_lo) w_lo = i_in_data.by;
        if (i_in_data.cy < w_lo) w_lo = i_in_data.cy;
        if (i_in_data.by > w_hi) w_hi = i_in_data.by;
        if (i_in_data.cy > w_hi) w_hi = i_in_data.cy;
    end

    // Row pointer range check and address
    logic [31:0]       w_ptr32;
    logic              w_ptr_ok;
    assign w_ptr32  = 32'(r_ptr);
    assign w_ptr_ok = (r_ptr < r_cnt) && (w_ptr32 < 32'(MAX_ROWS));

    // Edge setup: endpoints, major axis, swap
    logic [C-1:0]      w_x0, w_y0, w_x1, w_y1;
    logic [C-1:0]      w_adx, w_ady, w_len, w_md, w_sx0, w_sy0, w_sx1, w_sy1;
    logic              w_xm, w_swap, w_edge_skip, w_sdir;
    always_comb begin
        logic signed [C:0] ddx, ddy;
        unique case (i_cmd.edge_sel)
            EDGE_AB: begin
                w_x0 = r_ax; w_y0 = r_ay; w_x1 = r_bx; w_y1 = r_by;
            end
            EDGE_BC: begin
                w_x0 = r_bx; w_y0 = r_by; w_x1 = r_cx; w_y1 = r_cy;
            end
            default: begin
                w_x0 = r_cx; w_y0 = r_cy; w_x1 = r_ax; w_y1 = r_ay;
            end
        endcase
        ddx   = $signed({1'b0, w_x1}) - $signed({1'b0, w_x0});
        ddy   = $signed({1'b0, w_y1}) - $signed({1'b0, w_y0});
        w_adx = ddx[C] ? C'(-ddx) : ddx[C-1:0];
        w_ady = ddy[C] ? C'(-ddy) : ddy[C-1:0];
        w_xm  = (w_adx > w_ady);
        w_swap = w_xm ? (w_x0 > w_x1) : (w_y0 > w_y1);
        w_sx0 = w_swap ? w_x1 : w_x0;
        w_sy0 = w_swap ? w_y1 : w_y0;
        w_sx1 = w_swap ? w_x0 : w_x1;
        w_sy1 = w_swap ? w_y0 : w_y1;
        w_len = w_xm ? w_adx : w_ady;
        w_md  = w_xm ? w_ady : w_adx;
        w_sdir = w_xm ? (w_sy1 < w_sy0) : (w_sx1 < w_sx0);
        w_edge_skip = (w_adx == '0) && (w_ady == '0);
    end

    // Current mark position and span merge
    logic [C-1:0]      w_row, w_col;
    logic [ROW_W-1:0]  w_midx;
    logic [31:0]       w_midx32;
    logic              w_mark_ok;
    t_row_ent          w_rd, w_merged;
    assign w_row     = r_xmaj ? r_pos : r_maj;
    assign w_col     = r_xmaj ? r_maj : r_pos;
    assign w_midx    = {1'b0, w_row} - {1'b0, r_top};
    assign w_midx32  = 32'(w_midx);
    assign w_mark_ok = (w_midx < r_cnt) && (w_midx32 < 32'(MAX_ROWS));

    always_comb begin
        w_merged.touched = 1'b1;
        if (!w_rd.touched) begin
            w_merged.left  = w_col;
            w_merged.right = w_col;
        end else begin
            w_merged.left  = (w_col < w_rd.left)  ? w_col : w_rd.left;
            w_merged.right = (w_col > w_rd.right) ? w_col : w_rd.right;
        end
    end

    // Span table
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    t_row_ent          w_wdata;
    logic [ENT_W-1:0]  w_rdata;
    assign w_we    = i_cmd.clr_wr | i_cmd.mark_wr;
    assign w_waddr = i_cmd.clr_wr ? w_ptr32[ADDR_W-1:0] : w_midx32[ADDR_W-1:0];
    assign w_wdata = i_cmd.clr_wr ? t_row_ent'('0) : w_merged;
    assign w_raddr = i_cmd.seek_rd ? w_ptr32[ADDR_W-1:0] : w_midx32[ADDR_W-1:0];
    assign w_rd    = t_row_ent'(w_rdata);

    trsr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ROWS)
    ) u_span_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (ENT_W'(w_wdata)),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Multiplier operand select: term j is (U1 - U2) x (V1 - V2)
    logic [1:0]        w_j;
    logic [C-1:0]      w_u1x, w_u1y, w_u2x, w_u2y, w_v1x, w_v1y, w_v2x, w_v2y;
    logic signed [C:0] w_opa, w_opb;
    logic signed [AREA_W-1:0] w_prod;
    logic [2:0]        w_prev;
    logic signed [AREA_W:0] w_cross;
    logic [AREA_W-1:0] w_cross_abs;
    assign w_j = i_cmd.mul_k[2:1];
    always_comb begin
        unique case (w_j)
            2'd1: begin
                w_u1x = r_px; w_u1y = r_py; w_u2x = r_bx; w_u2y = r_by;
                w_v1x = r_px; w_v1y = r_py; w_v2x = r_cx; w_v2y = r_cy;
            end
            2'd2: begin
                w_u1x = r_px; w_u1y = r_py; w_u2x = r_cx; w_u2y = r_cy;
                w_v1x = r_px; w_v1y = r_py; w_v2x = r_ax; w_v2y = r_ay;
            end
            default: begin
                w_u1x = r_ax; w_u1y = r_ay; w_u2x = r_bx; w_u2y = r_by;
                w_v1x = r_cx; w_v1y = r_cy; w_v2x = r_bx; w_v2y = r_by;
            end
        endcase
        if (!i_cmd.mul_k[0]) begin
            w_opa = $signed({1'b0, w_u1x}) - $signed({1'b0, w_u2x});
            w_opb = $signed({1'b0, w_v1y}) - $signed({1'b0, w_v2y});
        end else begin
            w_opa = $signed({1'b0, w_u1y}) - $signed({1'b0, w_u2y});
            w_opb = $signed({1'b0, w_v1x}) - $signed({1'b0, w_v2x});
        end
    end
    assign w_prod      = w_opa * w_opb;
    assign w_prev      = i_cmd.mul_k - 3'd1;
    assign w_cross     = (AREA_W+1)'(r_acc) - (AREA_W+1)'(r_prod);
    assign w_cross_abs = w_cross[AREA_W] ? AREA_W'(-w_cross) : AREA_W'(w_cross);

    // Divider operands: numerator times 255 against the total area
    logic signed [AREA_W+1:0] w_rem;
    logic [AREA_W-1:0] w_num;
    logic              w_npos;
    logic [NUM_W-1:0]  w_n, w_t8, w_d, w_dsub;
    logic              w_ge;
    logic [7:0]        w_qfin;
    assign w_rem = $signed({2'b00, r_area[0]}) - $signed({2'b00, r_area[1]})
                 - $signed({2'b00, r_area[2]});
    always_comb begin
        unique case (i_cmd.ch)
            CH_RED: begin
                w_num  = r_area[1];
                w_npos = (r_area[1] != '0);
            end
            CH_GREEN: begin
                w_num  = r_area[2];
                w_npos = (r_area[2] != '0);
            end
            default: begin
                w_num  = w_rem[AREA_W-1:0];
                w_npos = !w_rem[AREA_W+1] && (w_rem != '0);
            end
        endcase
    end
    assign w_n    = {w_num, 8'd0} - NUM_W'(w_num);
    assign w_t8   = {r_area[0], 8'd0};
    assign w_d    = NUM_W'(r_area[0]) << i_cmd.div_b;
    assign w_ge   = (r_drem >= w_d);
    assign w_dsub = r_drem - w_d;
    assign w_qfin = {r_q[6:0], w_ge};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_top       <= '0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_top <= w_lo;
                r_cnt <= ROW_W'(w_hi - w_lo) + ROW_W'(1);
            end
            // Row pointer for clearing and seeking
            if (i_cmd.load || i_cmd.seek_zero) begin
                r_ptr <= '0;
            end else if (i_cmd.clr_wr || i_cmd.seek_inc) begin
                r_ptr <= r_ptr + ROW_W'(1);
            end else if (i_cmd.seek_next) begin
                r_ptr <= r_cur_row + ROW_W'(1);
            end
            // Cursor
            if (i_cmd.seek_hit) begin
                r_cur_row <= r_ptr;
                r_cur_col <= w_rd.left;
                r_busy    <= 1'b1;
            end else if (i_cmd.seek_fail) begin
                r_cur_row <= r_ptr;
                r_cur_col <= '0;
                r_busy    <= 1'b0;
            end else if (i_cmd.col_inc) begin
                r_cur_col <= r_cur_col + C'(1);
            end
            // Output beat register
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax <= i_in_data.ax; r_ay <= i_in_data.ay;
            r_bx <= i_in_data.bx; r_by <= i_in_data.by;
            r_cx <= i_in_data.cx; r_cy <= i_in_data.cy;
        end
        if (i_cmd.seek_hit) begin
            r_cur_right <= w_rd.right;
        end
        // Bresenham stepper
        if (i_cmd.edge_setup) begin
            r_xmaj <= w_xm;
            r_dir  <= w_sdir;
            r_maj  <= w_xm ? w_sx0 : w_sy0;
            r_pos  <= w_xm ? w_sy0 : w_sx0;
            r_rem  <= w_len;
            r_2md  <= {w_md, 1'b0};
            r_2len <= {w_len, 1'b0};
            r_p    <= $signed(P_W'({w_md, 1'b0})) - $signed(P_W'(w_len));
        end else if (i_cmd.walk_adv || i_cmd.mark_wr) begin
            r_maj <= r_maj + C'(1);
            r_rem <= r_rem - C'(1);
            if (!r_p[P_W-1]) begin
                r_pos <= r_dir ? r_pos - C'(1) : r_pos + C'(1);
                r_p   <= r_p - $signed(P_W'(r_2len)) + $signed(P_W'(r_2md));
            end else begin
                r_p   <= r_p + $signed(P_W'(r_2md));
            end
        end
        // Pixel position
        if (i_cmd.pix_start) begin
            r_px <= r_cur_col;
            r_py <= C'(ROW_W'(r_top) + r_cur_row);
        end
        // Area products
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_k != MUL_LAST) begin
                r_prod <= w_prod;
            end
            if (i_cmd.mul_k != 3'd0) begin
                if (!w_prev[0]) begin
                    r_acc <= r_prod;
                end else begin
                    r_area[w_prev[2:1]] <= w_cross_abs;
                end
            end
        end
        // Restoring divide, one quotient bit a cycle
        if (i_cmd.div_init) begin
            r_drem  <= w_n;
            r_dzero <= (r_area[0] == '0) || !w_npos;
            r_dsat  <= (w_n >= w_t8);
            r_q     <= '0;
        end else if (i_cmd.div_step) begin
            if (w_ge) begin
                r_drem <= w_dsub;
            end
            r_q <= w_qfin;
            if (i_cmd.div_last) begin
                r_rgb[i_cmd.ch] <= r_dzero ? 8'd0 : (r_dsat ? 8'd255 : w_qfin);
            end
        end
        if (i_cmd.out_load) begin
            r_out.pixel_x <= r_px;
            r_out.pixel_y <= r_py;
            r_out.red     <= r_rgb[CH_RED];
            r_out.green   <= r_rgb[CH_GREEN];
            r_out.blue    <= r_rgb[CH_BLUE];
            r_out.last    <= !r_busy;
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.ptr_ok       = w_ptr_ok;
        o_sts.edge_skip    = w_edge_skip;
        o_sts.mark_ok      = w_mark_ok;
        o_sts.walk_last    = (r_rem == '0);
        o_sts.touched      = w_rd.touched;
        o_sts.busy         = r_busy;
        o_sts.col_lt_right = (r_cur_col < r_cur_right);
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A result never overwrites a beat still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output beat overwritten");

    // Span merge always follows its table read
    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark_wr |-> $past(i_cmd.mark_rd))
        else $error("span write without read");

    // A seek only lands on a touched, in-range row
    a_seek_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seek_hit |-> (w_rd.touched && $past(w_ptr_ok)))
        else $error("seek landed on an untouched row");

    // Clearing stays inside the triangle's rows
    a_clear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_wr |-> (r_ptr < r_cnt))
        else $error("clear beyond row count");

endmodule

### design/triangle_span_rasterizer_core.sv
// Step beat: the multiplier forms the three areas, the divider finds each colour in turn,
// then the column advances and the result is emitted; a move to a new row reads span-table
// rows in turn (read, check). Load beat: the span table is cleared, then per edge a setup
// and, per marked pixel, a read and a merge write, then the row seek. One beat at a time;
// the output register lets a new beat in while a result waits. Synchronous active-low
// reset: no triangle, no result pending.
module triangle_span_rasterizer_core #(
    parameter int MAX_ROWS = trsr_pkg::MAX_ROWS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  trsr_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output trsr_pkg::t_out o_out_data
);
    import trsr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    trsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath and span table
    trsr_dp #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
